@@ rtl/ihq_pkg.sv @@
// Shared types and codes for the indexed binary heap queue.
// No dependencies; imported by the top level indexed_binary_heap_queue.
`default_nettype none
package ihq_pkg;

	localparam int ID_BITS  = 8;
	localparam int ID_COUNT = 256;
	localparam int OUT_KEY_BITS = 32;

	typedef enum logic [1:0] {
		KIND_INSERT = 2'd0,
		KIND_REMOVE = 2'd1,
		KIND_CHANGE = 2'd2,
		KIND_LOOKUP = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_FULL    = 3'd1,
		ST_EMPTY   = 3'd2,
		ST_ABSENT  = 3'd3,
		ST_PRESENT = 3'd4
	} status_t;

endpackage
`default_nettype wire

@@ rtl/indexed_binary_heap_queue.sv @@
// Top level of the indexed binary heap queue: sequencer, slot and position memories.
// Depends on ihq_pkg, ihq_ram, ihq_cmp.
//
//  channel | valid     | stall     | payload
//  in      | in_valid  | in_stall  | kind, item_id, key
//  out     | out_valid | out_stall | status, result_id, result_key, present, count,
//          |           |           | root_id, root_key
//  cfg     | cfg_we    | -         | cfg_wdata (priority_mode)
//
// One request at a time through one slot memory read port and one comparator. A look up
// reads the item's slot; an insert sifts up level by level; a remove takes the root, moves
// the last entry to the root and sifts it down, examining one level at a time; a change
// key sifts up like an insert or down like a remove.
// Reset clears the count, mode and id valid flags at once; no clearing pass.
// in_stall is high from acceptance until the result is taken on the output.
`default_nettype none
module indexed_binary_heap_queue
	import ihq_pkg::*;
#(
	parameter int CAPACITY = 256,
	parameter int KEY_BITS = 32
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic                              cfg_wdata,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [1:0]                        kind,
	input  wire logic [ID_BITS-1:0]                item_id,
	input  wire logic [OUT_KEY_BITS-1:0]           key,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [2:0]                             status,
	output logic [ID_BITS-1:0]                     result_id,
	output logic [OUT_KEY_BITS-1:0]                result_key,
	output logic                                   present,
	output logic [$clog2(CAPACITY+1)-1:0]          count,
	output logic [ID_BITS-1:0]                     root_id,
	output logic [OUT_KEY_BITS-1:0]                root_key
);
	localparam int KW = (KEY_BITS < OUT_KEY_BITS) ? KEY_BITS : OUT_KEY_BITS;
	localparam int PW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int LW = PW + 2;
	localparam int SW = ID_BITS + KW;

	typedef enum logic [4:0] {
		S_IDLE, S_DISPATCH, S_RM0, S_RM1, S_CH0, S_CH1, S_LK0,
		S_UP, S_UP_CMP, S_DOWN, S_DN_L, S_DN_R, S_DN_CMP,
		S_PLACE, S_FIN, S_FIN_RD, S_OUT
	} state_t;

	state_t              state_q;
	logic                mode_q;
	kind_t               kind_q;
	logic [ID_BITS-1:0]  id_q;
	logic [KW-1:0]       key_q;
	logic [CW-1:0]       count_q;
	logic [PW-1:0]       cur_q;
	logic [PW-1:0]       pick_pos_q;
	logic [ID_BITS-1:0]  pick_id_q;
	logic [KW-1:0]       pick_key_q;
	logic [ID_COUNT-1:0] placed_q;
	status_t             status_q;
	logic [ID_BITS-1:0]  rid_q;
	logic [KW-1:0]       rkey_q;
	logic                pres_q;
	logic [ID_BITS-1:0]  root_id_q;
	logic [KW-1:0]       root_key_q;

	// slot memory
	logic                slot_we;
	logic [PW-1:0]       slot_waddr, slot_raddr;
	logic [SW-1:0]       slot_wdata, slot_rdata;
	logic [ID_BITS-1:0]  rd_id;
	logic [KW-1:0]       rd_key;

	// position memory
	logic                pos_we;
	logic [ID_BITS-1:0]  pos_waddr;
	logic [PW-1:0]       pos_wdata, pos_rdata;

	logic [KW-1:0]       cmp_a, cmp_b;
	logic                outranks;
	logic [PW-1:0]       parent;
	logic [LW-1:0]       left_w, right_w, count_w;
	logic                here;

	assign rd_id   = slot_rdata[SW-1 -: ID_BITS];
	assign rd_key  = slot_rdata[KW-1:0];
	assign parent  = (cur_q - PW'(1)) >> 1;
	assign left_w  = {1'b0, cur_q, 1'b1};
	assign right_w = left_w + LW'(1);
	assign count_w = LW'(count_q);
	assign here    = placed_q[id_q];

	ihq_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_slot_ram (
		.clk   (clk),
		.we    (slot_we),
		.waddr (slot_waddr),
		.wdata (slot_wdata),
		.raddr (slot_raddr),
		.rdata (slot_rdata)
	);

	ihq_ram #(.WIDTH(PW), .DEPTH(ID_COUNT)) u_pos_ram (
		.clk   (clk),
		.we    (pos_we),
		.waddr (pos_waddr),
		.wdata (pos_wdata),
		.raddr (item_id),
		.rdata (pos_rdata)
	);

	ihq_cmp #(.KW(KW)) u_cmp (
		.mode     (mode_q),
		.a        (cmp_a),
		.b        (cmp_b),
		.outranks (outranks)
	);

	// comparator operand selection
	always_comb begin
		cmp_a = key_q;
		cmp_b = rd_key;
		case (state_q)
			S_DN_R: begin
				cmp_a = rd_key;
				cmp_b = pick_key_q;
			end
			S_DN_CMP, S_CH1: begin
				cmp_a = pick_key_q;
				cmp_b = key_q;
			end
			default: begin
				cmp_a = key_q;
				cmp_b = rd_key;
			end
		endcase
	end

	// slot read address
	always_comb begin
		case (state_q)
			S_DISPATCH: slot_raddr = (kind_q == KIND_REMOVE) ? PW'(0) : pos_rdata;
			S_RM0:      slot_raddr = PW'(count_q - CW'(1));
			S_UP:       slot_raddr = parent;
			S_DOWN:     slot_raddr = left_w[PW-1:0];
			S_DN_L:     slot_raddr = right_w[PW-1:0];
			default:    slot_raddr = PW'(0);
		endcase
	end

	// memory writes: move a parent or child into the hole, or drop the item in
	always_comb begin
		slot_we    = 1'b0;
		slot_waddr = cur_q;
		slot_wdata = {id_q, key_q};
		pos_we     = 1'b0;
		pos_waddr  = id_q;
		pos_wdata  = cur_q;
		case (state_q)
			S_UP_CMP: begin
				slot_we    = outranks;
				slot_wdata = slot_rdata;
				pos_we     = outranks;
				pos_waddr  = rd_id;
			end
			S_DN_CMP: begin
				slot_we    = outranks;
				slot_wdata = {pick_id_q, pick_key_q};
				pos_we     = outranks;
				pos_waddr  = pick_id_q;
			end
			S_PLACE: begin
				slot_we = 1'b1;
				pos_we  = 1'b1;
			end
			default: begin
				slot_we = 1'b0;
				pos_we  = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			mode_q     <= 1'b0;
			count_q    <= '0;
			placed_q   <= '0;
			kind_q     <= KIND_INSERT;
			status_q   <= ST_OK;
			id_q       <= '0;
			key_q      <= '0;
			cur_q      <= '0;
			pick_pos_q <= '0;
			pick_id_q  <= '0;
			pick_key_q <= '0;
			rid_q      <= '0;
			rkey_q     <= '0;
			pres_q     <= 1'b0;
			root_id_q  <= '0;
			root_key_q <= '0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						kind_q   <= kind_t'(kind);
						id_q     <= item_id;
						key_q    <= key[KW-1:0];
						status_q <= ST_OK;
						rid_q    <= item_id;
						rkey_q   <= '0;
						pres_q   <= 1'b0;
						state_q  <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					case (kind_q)
						KIND_INSERT: begin
							if (here) begin
								status_q <= ST_PRESENT;
								state_q  <= S_FIN;
							end else if (count_q == CW'(CAPACITY)) begin
								status_q <= ST_FULL;
								state_q  <= S_FIN;
							end else begin
								cur_q   <= count_q[PW-1:0];
								count_q <= count_q + CW'(1);
								state_q <= S_UP;
							end
						end
						KIND_REMOVE: begin
							if (count_q == '0) begin
								status_q <= ST_EMPTY;
								rid_q    <= '0;
								state_q  <= S_FIN;
							end else begin
								state_q <= S_RM0;
							end
						end
						KIND_CHANGE: begin
							pres_q <= here;
							cur_q  <= pos_rdata;
							if (!here) begin
								status_q <= ST_ABSENT;
								state_q  <= S_FIN;
							end else begin
								state_q <= S_CH0;
							end
						end
						default: begin
							pres_q <= here;
							if (!here) begin
								status_q <= ST_ABSENT;
								state_q  <= S_FIN;
							end else begin
								state_q <= S_LK0;
							end
						end
					endcase
				end
				S_RM0: begin
					rid_q   <= rd_id;
					rkey_q  <= rd_key;
					state_q <= S_RM1;
				end
				S_RM1: begin
					// last entry sifts down from the root
					placed_q[rid_q] <= 1'b0;
					count_q <= count_q - CW'(1);
					id_q    <= rd_id;
					key_q   <= rd_key;
					cur_q   <= '0;
					state_q <= (count_q == CW'(1)) ? S_FIN : S_DOWN;
				end
				S_CH0: begin
					pick_key_q <= rd_key;
					state_q    <= outranks ? S_UP : S_CH1;
				end
				S_CH1: begin
					state_q <= outranks ? S_DOWN : S_FIN;
				end
				S_LK0: begin
					rkey_q  <= rd_key;
					state_q <= S_FIN;
				end
				S_UP: begin
					state_q <= (cur_q == '0) ? S_PLACE : S_UP_CMP;
				end
				S_UP_CMP: begin
					if (outranks) begin
						cur_q   <= parent;
						state_q <= S_UP;
					end else begin
						state_q <= S_PLACE;
					end
				end
				S_DOWN: begin
					state_q <= (left_w >= count_w) ? S_PLACE : S_DN_L;
				end
				S_DN_L: begin
					pick_id_q  <= rd_id;
					pick_key_q <= rd_key;
					pick_pos_q <= left_w[PW-1:0];
					state_q    <= (right_w < count_w) ? S_DN_R : S_DN_CMP;
				end
				S_DN_R: begin
					// left child wins on equal keys
					if (outranks) begin
						pick_id_q  <= rd_id;
						pick_key_q <= rd_key;
						pick_pos_q <= right_w[PW-1:0];
					end
					state_q <= S_DN_CMP;
				end
				S_DN_CMP: begin
					if (outranks) begin
						cur_q   <= pick_pos_q;
						state_q <= S_DOWN;
					end else begin
						state_q <= S_PLACE;
					end
				end
				S_PLACE: begin
					placed_q[id_q] <= 1'b1;
					state_q <= S_FIN;
				end
				S_FIN: begin
					state_q <= S_FIN_RD;
				end
				S_FIN_RD: begin
					root_id_q  <= (count_q == '0) ? '0 : rd_id;
					root_key_q <= (count_q == '0) ? '0 : rd_key;
					state_q    <= S_OUT;
				end
				S_OUT: begin
					if (!out_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_stall   = (state_q != S_IDLE);
	assign out_valid  = (state_q == S_OUT);
	assign status     = status_q;
	assign result_id  = rid_q;
	assign result_key = OUT_KEY_BITS'(rkey_q);
	assign present    = pres_q;
	assign count      = count_q;
	assign root_id    = root_id_q;
	assign root_key   = OUT_KEY_BITS'(root_key_q);

	a_busy_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("result shown while a new request could enter");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count beyond capacity");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("request accepted but block not busy next cycle");

	a_absent_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status_q == ST_ABSENT) |-> !pres_q)
		else $error("absent status with present flag set");

	a_empty_root: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && count_q == '0) |-> (root_id_q == '0 && root_key_q == '0))
		else $error("root not zero on empty heap");

endmodule
`default_nettype wire

@@ rtl/ihq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module ihq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

@@ rtl/ihq_cmp.sv @@
// Shared priority comparator: true when key a strictly outranks key b.
// No dependencies.
`default_nettype none
module ihq_cmp #(
	parameter int KW = 32
) (
	input  wire logic          mode,
	input  wire logic [KW-1:0] a,
	input  wire logic [KW-1:0] b,
	output logic               outranks
);
	assign outranks = mode ? (a > b) : (a < b);
endmodule
`default_nettype wire
